/* sv/indexed_max_heap_queue_unit_macros.svh */
// assertion macros for the heap queue checker
`ifndef INDEXED_MAX_HEAP_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MAX_HEAP_QUEUE_UNIT_MACROS_SVH

// property that must hold at every edge outside reset
`define IMHQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication whose consequent is checked in the next cycle
`define IMHQ_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/imhq_pkg.sv */
package imhq_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int ID_COUNT      = 64;
	localparam int ID_W          = 6;
	localparam int KEY_OUT_W     = 32;
	localparam int CNT_OUT_W     = 7;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_INCREASE = 2'd2,
		OP_PEEK     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FULL    = 3'd2,
		ST_SMALLER = 3'd3,
		ST_ABSENT  = 3'd4,
		ST_PRESENT = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [ID_W-1:0]      item_id;
		logic signed [31:0]   key_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ID_W-1:0]      out_id;
		logic signed [31:0]   out_key;
		logic [CNT_OUT_W-1:0] entry_count;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INC_RD,
		S_INC_CHK,
		S_EXT_RD,
		S_EXT_WR,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_TOP_RD,
		S_TOP_WAIT,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load_in;     // capture input item
		logic    set_status;
		status_t status;
		logic    ins_write;   // write new entry at the end, count up
		logic    ext_rd;      // read root and last slot
		logic    ext_wr;      // move last entry to root, count down
		logic    inc_rd;      // read entry at the mapped slot
		logic    inc_wr;      // write raised key in place
		logic    up_rd;       // read parent
		logic    up_move;     // swap with parent
		logic    dn_rd;       // read both children
		logic    dn_move;     // swap with larger child
		logic    top_rd;      // read root for the result
		logic    top_cap;     // capture root into the result
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic     empty;
		logic     full;
		logic     present;
		logic     smaller;
		logic     at_root;
		logic     up_swap;
		logic     dn_swap;
		opcode_t  op;
	} sts_t;

endpackage

/* sv/imhq_ctrl.sv */
module imhq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_free,
	input  imhq_pkg::sts_t sts,
	output imhq_pkg::cmd_t cmd,
	output logic           busy,
	output logic           res_load
);
	import imhq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_DECODE;
			S_DECODE: begin
				unique case (sts.op)
					OP_INSERT: state_d = (sts.full || sts.present) ? S_TOP_RD : S_UP_RD;
					OP_EXTRACT: state_d = sts.empty ? S_TOP_RD : S_EXT_RD;
					OP_INCREASE: state_d = sts.present ? S_INC_RD : S_TOP_RD;
					OP_PEEK: state_d = S_TOP_RD;
					default: state_d = S_TOP_RD;
				endcase
			end
			S_INC_RD: state_d = S_INC_CHK;
			S_INC_CHK: state_d = sts.smaller ? S_TOP_RD : S_UP_RD;
			S_EXT_RD: state_d = S_EXT_WR;
			S_EXT_WR: state_d = S_DN_RD;
			S_UP_RD: state_d = sts.at_root ? S_TOP_RD : S_UP_CMP;
			S_UP_CMP: state_d = sts.up_swap ? S_UP_RD : S_TOP_RD;
			S_DN_RD: state_d = S_DN_CMP;
			S_DN_CMP: state_d = sts.dn_swap ? S_DN_RD : S_DONE;
			S_TOP_RD: state_d = S_TOP_WAIT;
			S_TOP_WAIT: state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		busy = (state_q != S_IDLE);
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: cmd.load_in = in_fire;
			S_DECODE: begin
				cmd.set_status = 1'b1;
				unique case (sts.op)
					OP_INSERT: begin
						if (sts.full) cmd.status = ST_FULL;
						else if (sts.present) cmd.status = ST_PRESENT;
						else cmd.ins_write = 1'b1;
					end
					OP_EXTRACT: if (sts.empty) cmd.status = ST_EMPTY;
					OP_INCREASE: if (!sts.present) cmd.status = ST_ABSENT;
					OP_PEEK: if (sts.empty) cmd.status = ST_EMPTY;
					default: cmd.status = ST_OK;
				endcase
			end
			S_INC_RD: cmd.inc_rd = 1'b1;
			S_INC_CHK: begin
				if (sts.smaller) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_SMALLER;
				end else begin
					cmd.inc_wr = 1'b1;
				end
			end
			S_EXT_RD: cmd.ext_rd = 1'b1;
			S_EXT_WR: cmd.ext_wr = 1'b1;
			S_UP_RD: cmd.up_rd = !sts.at_root;
			S_UP_CMP: cmd.up_move = sts.up_swap;
			S_DN_RD: cmd.dn_rd = 1'b1;
			S_DN_CMP: cmd.dn_move = sts.dn_swap;
			S_TOP_RD: cmd.top_rd = 1'b1;
			S_TOP_WAIT: cmd.top_cap = 1'b1;
			S_DONE: res_load = out_free;
			default: ;
		endcase
	end

endmodule

/* sv/imhq_dpath.sv */
module imhq_dpath #(
	parameter int CAPACITY  = imhq_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = imhq_pkg::KEY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  imhq_pkg::in_item_t  in_item,
	input  imhq_pkg::cmd_t      cmd,
	output imhq_pkg::sts_t      sts,
	output imhq_pkg::out_item_t res
);
	import imhq_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_WIDTH + ID_W;

	typedef logic signed [KEY_WIDTH-1:0] key_t;

	// heap entries packed as key and id
	logic [EW-1:0]       heap_mem [CAPACITY];
	logic [SW-1:0]       slot_mem [ID_COUNT];
	logic [ID_COUNT-1:0] present_q;
	logic [CW-1:0]       size_q;

	opcode_t         op_q;
	logic [ID_W-1:0] id_q;
	key_t            key_q;
	status_t         status_q;
	logic [ID_W-1:0] rid_q;
	key_t            rkey_q;

	// entry being sifted and its slot
	logic [SW-1:0]   i_q;
	key_t            mk_q;
	logic [ID_W-1:0] mid_q;

	logic [EW-1:0]   rd_a_q, rd_b_q;
	logic [SW-1:0]   slot_rd_q;

	key_t            ka, kb;
	logic [ID_W-1:0] da, db;
	logic [SW+1:0]   lft, rgt;
	logic [SW-1:0]   par, child;
	logic            lv, rv, dn_l, dn_r;

	logic [SW-1:0]   ra, rb, wa, wb;
	logic [EW-1:0]   wda, wdb;
	logic            wea, web;
	logic            swa, swb;
	logic [ID_W-1:0] swa_id, swb_id;
	logic [SW-1:0]   swa_slot, swb_slot;

	assign ka = rd_a_q[EW-1:ID_W];
	assign da = rd_a_q[ID_W-1:0];
	assign kb = rd_b_q[EW-1:ID_W];
	assign db = rd_b_q[ID_W-1:0];

	assign lft = {1'b0, i_q, 1'b1};
	assign rgt = lft + (SW+2)'(1);
	assign par = (i_q - SW'(1)) >> 1;
	assign lv = lft < (SW+2)'(size_q);
	assign rv = rgt < (SW+2)'(size_q);

	// left child first, right child only if strictly larger than that pick
	assign dn_l = lv && (mk_q < ka);
	assign dn_r = rv && ((dn_l ? ka : mk_q) < kb);
	assign child = dn_r ? rgt[SW-1:0] : lft[SW-1:0];

	always_comb begin
		sts.empty   = (size_q == '0);
		sts.full    = (size_q >= CW'(CAPACITY));
		sts.present = present_q[id_q];
		sts.smaller = key_q < ka;
		sts.at_root = (i_q == '0);
		sts.up_swap = kb < mk_q;
		sts.dn_swap = dn_l || dn_r;
		sts.op      = op_q;
	end

	always_comb begin
		ra = '0;
		rb = '0;
		wea = 1'b0;
		web = 1'b0;
		wa = i_q;
		wb = par;
		wda = rd_b_q;
		wdb = {mk_q, mid_q};
		swa = 1'b0;
		swb = 1'b0;
		swa_id = db;
		swa_slot = i_q;
		swb_id = mid_q;
		swb_slot = par;
		if (cmd.ins_write) begin
			wea = 1'b1;
			wa = size_q[SW-1:0];
			wda = {key_q, id_q};
			swa = 1'b1;
			swa_id = id_q;
			swa_slot = size_q[SW-1:0];
		end
		if (cmd.ext_rd) begin
			ra = '0;
			rb = SW'(size_q - CW'(1));
		end
		if (cmd.ext_wr) begin
			wea = 1'b1;
			wa = '0;
			wda = rd_b_q;
			swa = 1'b1;
			swa_id = db;
			swa_slot = '0;
		end
		if (cmd.inc_rd) ra = slot_rd_q;
		if (cmd.inc_wr) begin
			wea = 1'b1;
			wa = i_q;
			wda = {key_q, da};
		end
		if (cmd.up_rd) rb = par;
		if (cmd.up_move) begin
			wea = 1'b1;
			web = 1'b1;
			wa = i_q;
			wda = rd_b_q;
			wb = par;
			wdb = {mk_q, mid_q};
			swa = 1'b1;
			swa_id = db;
			swa_slot = i_q;
			swb = 1'b1;
			swb_id = mid_q;
			swb_slot = par;
		end
		if (cmd.dn_rd) begin
			ra = lft[SW-1:0];
			rb = rgt[SW-1:0];
		end
		if (cmd.dn_move) begin
			wea = 1'b1;
			web = 1'b1;
			wa = i_q;
			wda = dn_r ? rd_b_q : rd_a_q;
			wb = child;
			wdb = {mk_q, mid_q};
			swa = 1'b1;
			swa_id = dn_r ? db : da;
			swa_slot = i_q;
			swb = 1'b1;
			swb_id = mid_q;
			swb_slot = child;
		end
		if (cmd.top_rd) ra = '0;
	end

	always_ff @(posedge clk) begin
		if (wea) heap_mem[wa] <= wda;
		if (web) heap_mem[wb] <= wdb;
		if (swa) slot_mem[swa_id] <= swa_slot;
		if (swb) slot_mem[swb_id] <= swb_slot;
		rd_a_q <= heap_mem[ra];
		rd_b_q <= heap_mem[rb];
		slot_rd_q <= slot_mem[id_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			size_q <= '0;
		end else begin
			if (cmd.ins_write) begin
				size_q <= size_q + CW'(1);
				present_q[id_q] <= 1'b1;
			end
			if (cmd.ext_wr) begin
				size_q <= size_q - CW'(1);
				present_q[da] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode_t'(in_item.opcode);
			id_q <= in_item.item_id;
			key_q <= key_t'(in_item.key_value);
			status_q <= ST_OK;
		end
		if (cmd.set_status) status_q <= cmd.status;
		if (cmd.ins_write) begin
			i_q <= size_q[SW-1:0];
			mk_q <= key_q;
			mid_q <= id_q;
		end
		if (cmd.inc_rd) i_q <= slot_rd_q;
		if (cmd.inc_wr) begin
			mk_q <= key_q;
			mid_q <= id_q;
		end
		if (cmd.ext_wr) begin
			rid_q <= da;
			rkey_q <= ka;
			i_q <= '0;
			mk_q <= kb;
			mid_q <= db;
		end
		if (cmd.up_move) i_q <= par;
		if (cmd.dn_move) i_q <= child;
		if (cmd.top_cap) begin
			rid_q <= sts.empty ? '0 : da;
			rkey_q <= sts.empty ? '0 : ka;
		end
	end

	always_comb begin
		res.status      = status_q;
		res.out_id      = rid_q;
		res.out_key     = KEY_OUT_W'(rkey_q);
		res.entry_count = CNT_OUT_W'(size_q);
	end

endmodule

/* sv/indexed_max_heap_queue_unit.sv */
// flow: one item at a time, the next transfer accepted in the cycle after the result loads;
// each sift level takes a read state and a compare state, set by the registered heap
// memory reads
// reset: arst_n clears the presence bits, entry count and controller; heap memory
// keeps its contents and is read only where written
module indexed_max_heap_queue_unit #(
	parameter int CAPACITY  = imhq_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = imhq_pkg::KEY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  imhq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output imhq_pkg::out_item_t out_data
);
	import imhq_pkg::*;

	cmd_t      cmd;
	sts_t      sts;
	out_item_t res;
	logic      busy, res_load, in_fire;

	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;

	imhq_ctrl u_ctrl (
		.clk, .arst_n, .in_fire,
		.out_free(!out_valid || out_ready),
		.sts, .cmd, .busy, .res_load
	);

	imhq_dpath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dpath (
		.clk, .arst_n, .in_item(in_data), .cmd, .sts, .res
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) out_data <= res;
	end

endmodule

/* sv/imhq_checker.sv */
module imhq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input imhq_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input imhq_pkg::out_item_t out_data
);
	import imhq_pkg::*;
`include "indexed_max_heap_queue_unit_macros.svh"

	`IMHQ_ASSERT(a_count_range, !out_valid || out_data.entry_count <= 7'd64, "count out of range")
	`IMHQ_ASSERT(a_status_range, !out_valid || out_data.status <= ST_PRESENT, "bad status")
	`IMHQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`IMHQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item taken early")
endmodule

bind indexed_max_heap_queue_unit imhq_checker u_imhq_checker (.*);

/* sim/indexed_max_heap_queue_unit_test.sv */
module indexed_max_heap_queue_unit_test;
	import imhq_pkg::*;

	localparam int CAP = 64;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	indexed_max_heap_queue_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// heap model state
	logic signed [31:0] hp_key [CAP];
	logic [5:0] hp_id [CAP];
	int slot_map [64];
	bit present [64];
	int hp_count;
	int shadow_count;   // entries once all queued items have run, used to shape stimulus
	bit shadow_present [64];

	in_item_t pending_items[$];
	out_item_t expected_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	int error_count = 0;
	int result_count = 0;
	int idle_cycles = 0;
	int status_seen [6];

	// handshake as sampled at the last rising edge, so the driver knows a transfer took place
	logic in_ready_q = 1'b0;

	function automatic void swap_entries(int a, int b);
		logic signed [31:0] tk;
		logic [5:0] ti;
		slot_map[hp_id[a]] = b;
		slot_map[hp_id[b]] = a;
		tk = hp_key[a]; hp_key[a] = hp_key[b]; hp_key[b] = tk;
		ti = hp_id[a]; hp_id[a] = hp_id[b]; hp_id[b] = ti;
	endfunction

	function automatic void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!(hp_key[p] < hp_key[i])) break;
			swap_entries(i, p);
			i = p;
		end
	endfunction

	function automatic void bubble_down(int i);
		int l, r, big;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			big = i;
			if (l < hp_count && hp_key[big] < hp_key[l]) big = l;
			if (r < hp_count && hp_key[big] < hp_key[r]) big = r;
			if (big == i) break;
			swap_entries(i, big);
			i = big;
		end
	endfunction

	function automatic out_item_t heap_apply(in_item_t it);
		out_item_t res;
		bit removed;
		int s;
		res = '0;
		removed = 1'b0;
		res.status = ST_OK;
		case (opcode_t'(it.opcode))
			OP_INSERT: begin
				if (hp_count >= CAP) res.status = ST_FULL;
				else if (present[it.item_id]) res.status = ST_PRESENT;
				else begin
					s = hp_count;
					hp_count++;
					hp_id[s] = it.item_id;
					hp_key[s] = it.key_value;
					slot_map[it.item_id] = s;
					present[it.item_id] = 1'b1;
					bubble_up(s);
				end
			end
			OP_EXTRACT: begin
				if (hp_count == 0) res.status = ST_EMPTY;
				else begin
					res.out_id = hp_id[0];
					res.out_key = hp_key[0];
					removed = 1'b1;
					swap_entries(0, hp_count - 1);
					hp_count--;
					present[res.out_id] = 1'b0;
					bubble_down(0);
				end
			end
			OP_INCREASE: begin
				if (!present[it.item_id]) res.status = ST_ABSENT;
				else begin
					s = slot_map[it.item_id];
					if (it.key_value < hp_key[s]) res.status = ST_SMALLER;
					else begin
						hp_key[s] = it.key_value;
						bubble_up(s);
					end
				end
			end
			default: if (hp_count == 0) res.status = ST_EMPTY;
		endcase
		if (!removed && hp_count > 0) begin
			res.out_id = hp_id[0];
			res.out_key = hp_key[0];
		end
		res.entry_count = hp_count[6:0];
		return res;
	endfunction

	// tracks count and presence so that random ops can target present/absent ids
	task automatic queue_op(opcode_t op, logic [5:0] id, logic signed [31:0] key);
		in_item_t it;
		it.opcode = op;
		it.item_id = id;
		it.key_value = key;
		pending_items.push_back(it);
		case (op)
			OP_INSERT: if (shadow_count < CAP && !shadow_present[id]) begin
				shadow_present[id] = 1'b1;
				shadow_count++;
			end
			OP_EXTRACT: if (shadow_count > 0) shadow_count--;
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 7)) - 32'd4);
			default: return $signed($urandom());
		endcase
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready_q) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid && pending_items.size() > 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end
			out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		in_ready_q <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) expected_results.push_back(heap_apply(in_data));
			if (out_valid && out_ready) begin
				out_item_t exp_r;
				result_count++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: status %0d id %0d key %0d",
						out_data.status, out_data.out_id, out_data.out_key);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.status < 6) status_seen[exp_r.status]++;
					if (out_data.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, out_data.status);
						error_count++;
					end
					if (out_data.out_id !== exp_r.out_id) begin
						$error("out_id: expected %0d, got %0d", exp_r.out_id, out_data.out_id);
						error_count++;
					end
					if (out_data.out_key !== exp_r.out_key) begin
						$error("out_key: expected %0d, got %0d", exp_r.out_key,
							out_data.out_key);
						error_count++;
					end
					if (out_data.entry_count !== exp_r.entry_count) begin
						$error("entry_count: expected %0d, got %0d", exp_r.entry_count,
							out_data.entry_count);
						error_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		int waited;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		recv_hold = 1'b1;
		waited = 0;
		while (waited < 400) begin
			@(posedge clk);
			waited++;
		end
		recv_hold = 1'b0;
	end

	task automatic fill_random(int n);
		int r;
		logic [5:0] id;
		repeat (n) begin
			r = $urandom_range(0, 99);
			id = 6'($urandom());
			if (r < 40) begin
				// mostly fresh ids
				if ($urandom_range(0, 3) != 0) begin
					for (int k = 0; k < 64 && shadow_present[id]; k++) id = id + 6'd1;
				end
				queue_op(OP_INSERT, id, rand_key());
			end else if (r < 65) begin
				queue_op(OP_EXTRACT, id, rand_key());
			end else if (r < 90) begin
				// pick a present id most of the time
				if ($urandom_range(0, 4) != 0) begin
					for (int k = 0; k < 64 && !shadow_present[id]; k++) id = id + 6'd1;
				end
				queue_op(OP_INCREASE, id, rand_key());
			end else begin
				queue_op(OP_PEEK, id, rand_key());
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		hp_count = 0;
		shadow_count = 0;
		for (int k = 0; k < 64; k++) begin
			present[k] = 1'b0;
			shadow_present[k] = 1'b0;
			slot_map[k] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 23;
		recv_idle_pct = 88;
		// directed: empty cases, extremes, ties, errors
		queue_op(OP_PEEK, 6'd0, 32'sd0);
		queue_op(OP_EXTRACT, 6'd63, 32'sd0);
		queue_op(OP_INCREASE, 6'd5, 32'sd1);
		queue_op(OP_INSERT, 6'd63, 32'sh80000000);
		queue_op(OP_INSERT, 6'd0, 32'sh7fffffff);
		queue_op(OP_INSERT, 6'd0, 32'sd5);
		queue_op(OP_INSERT, 6'd21, 32'sh7fffffff);
		queue_op(OP_INSERT, 6'd42, 32'sd7);
		queue_op(OP_INCREASE, 6'd42, 32'sd6);
		queue_op(OP_INCREASE, 6'd42, 32'sd7);
		queue_op(OP_INCREASE, 6'd63, 32'sh7fffffff);
		queue_op(OP_INCREASE, 6'd10, 32'sd0);
		queue_op(OP_PEEK, 6'd63, 32'sh7fffffff);
		repeat (5) queue_op(OP_EXTRACT, 6'd0, 32'sd0);
		queue_op(OP_PEEK, 6'd0, 32'sd0);
		// fill to capacity then overflow, full check before presence
		for (int k = 0; k < 64; k++) queue_op(OP_INSERT, 6'(k), rand_key());
		queue_op(OP_INSERT, 6'd3, 32'sd1);
		queue_op(OP_INSERT, 6'd9, 32'sd1);
		repeat (64) queue_op(OP_EXTRACT, 6'd0, 32'sd0);

		fill_random(170);
		wait_drained();
		send_idle_pct = 88;
		recv_idle_pct = 23;
		fill_random(170);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_random(170);
		wait_drained();
		repeat (40) @(posedge clk);

		$display("%0d results checked: ok %0d, empty %0d, full %0d, smaller %0d,",
			result_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		$display("absent %0d, duplicate %0d, over three idle mixes and a long output stall",
			status_seen[4], status_seen[5]);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
